// ----- rtl/scc_pkg.sv -----
// shared types and constants for the strongly connected components block
// no dependencies; used by strongly_connected_components
`default_nettype none
package scc_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int VTX_W            = 6;
    localparam int CNT_W            = 7;
    localparam int KIND_W           = 2;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1_OUTER,
        ST_P2_OUTER,
        ST_P2_CHECK,
        ST_SCAN,
        ST_CHECK,
        ST_POP_LOAD,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/strongly_connected_components.sv -----
// strongly connected components by kosaraju's method, one shared edge scanner
// depends on scc_pkg
// a run scans the edges of each stack frame in each of two passes
// throughput: one transaction at a time, busy stays high for the whole run
// results leave as one-cycle strobes; the receiver cannot stall
// reset: synchronous active low, clears edge count, overflow flag, visited marks,
// sets vertex_count to its maximum; edge memory holds no reset
`default_nettype none
module strongly_connected_components #(
    parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = scc_pkg::MAX_EDGES_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    output logic                         o_busy,
    input  wire  [scc_pkg::KIND_W-1:0]   i_kind,
    input  wire  [scc_pkg::VTX_W-1:0]    i_edge_source,
    input  wire  [scc_pkg::VTX_W-1:0]    i_edge_target,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [scc_pkg::CNT_W-1:0]    i_cfg_data,
    output logic                         o_valid,
    output logic [scc_pkg::VTX_W-1:0]    o_vertex,
    output logic [scc_pkg::CNT_W-1:0]    o_component,
    output logic                         o_last,
    output logic                         o_edges_dropped
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int HW = $clog2(MAX_EDGES + 1);
    localparam int XW = scc_pkg::VTX_W;
    localparam int NW = scc_pkg::CNT_W;

    // memories
    logic [XW-1:0] m_from  [MAX_EDGES];
    logic [XW-1:0] m_to    [MAX_EDGES];
    logic [XW-1:0] m_fin   [MAX_VERTICES];
    logic [XW-1:0] m_stk_v [MAX_VERTICES];
    logic [HW-1:0] m_stk_c [MAX_VERTICES];

    scc_pkg::t_state r_state, n_state;
    logic [NW-1:0] r_vc;
    logic [HW-1:0] r_held, n_held;
    logic          r_ovf, n_ovf;
    logic [MAX_VERTICES-1:0] r_vis, n_vis;
    logic          r_rev, n_rev;
    logic [NW-1:0] r_i, n_i;
    logic [CW-1:0] r_fin, n_fin;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_sp, n_sp;
    logic [NW-1:0] r_comp, n_comp;
    logic [XW-1:0] r_cur_v, n_cur_v;
    logic [HW-1:0] r_cur_c, n_cur_c;
    logic          r_pend, n_pend;
    logic [XW-1:0] r_pend_v, n_pend_v;
    logic [NW-1:0] r_pend_c, n_pend_c;
    logic          r_ov, n_ov;
    logic [XW-1:0] r_ovtx, n_ovtx;
    logic [NW-1:0] r_ocomp, n_ocomp;
    logic          r_olast, n_olast;

    logic [XW-1:0] r_rd_from, r_rd_to, r_rd_fin, r_rd_sv;
    logic [HW-1:0] r_rd_sc;

    logic          w_edge_we, w_fin_we, w_stk_we;
    logic [CW-1:0] w_sp_m1, w_k_m1;
    logic          w_emit;
    logic [XW-1:0] w_emit_v;
    logic [NW-1:0] w_emit_c;
    logic          w_start_walk;
    logic [XW-1:0] w_start_v;
    logic          w_in_use, w_match;
    logic [XW-1:0] w_nb;
    logic [NW-1:0] w_cfg_v;

    assign w_sp_m1 = r_sp - CW'(1);
    assign w_k_m1  = r_k - CW'(1);

    // edge memory: append on add, registered read at the cursor
    always_ff @(posedge i_clk) begin
        if (w_edge_we) begin
            m_from[r_held[AW-1:0]] <= i_edge_source;
            m_to[r_held[AW-1:0]]   <= i_edge_target;
        end
        r_rd_from <= m_from[r_cur_c[AW-1:0]];
        r_rd_to   <= m_to[r_cur_c[AW-1:0]];
    end

    // finish list memory
    always_ff @(posedge i_clk) begin
        if (w_fin_we) begin
            m_fin[r_fin[VW-1:0]] <= r_cur_v;
        end
        r_rd_fin <= m_fin[w_k_m1[VW-1:0]];
    end

    // walk stack memory, top frame lives in r_cur_v / r_cur_c
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            m_stk_v[r_sp[VW-1:0]] <= r_cur_v;
            m_stk_c[r_sp[VW-1:0]] <= r_cur_c + HW'(1);
        end
        r_rd_sv <= m_stk_v[w_sp_m1[VW-1:0]];
        r_rd_sc <= m_stk_c[w_sp_m1[VW-1:0]];
    end

    // config clamp
    always_comb begin
        w_cfg_v = i_cfg_data;
        if (w_cfg_v == '0) begin
            w_cfg_v = NW'(1);
        end else if (w_cfg_v > NW'(MAX_VERTICES)) begin
            w_cfg_v = NW'(MAX_VERTICES);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::ST_IDLE;
            r_vc    <= NW'(MAX_VERTICES);
            r_held  <= '0;
            r_ovf   <= 1'b0;
            r_vis   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_ovf   <= n_ovf;
            r_vis   <= n_vis;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vc <= w_cfg_v;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rev    <= n_rev;
        r_i      <= n_i;
        r_fin    <= n_fin;
        r_k      <= n_k;
        r_sp     <= n_sp;
        r_comp   <= n_comp;
        r_cur_v  <= n_cur_v;
        r_cur_c  <= n_cur_c;
        r_pend_v <= n_pend_v;
        r_pend_c <= n_pend_c;
        r_ovtx   <= n_ovtx;
        r_ocomp  <= n_ocomp;
        r_olast  <= n_olast;
    end

    // edge qualification for the current frame
    always_comb begin
        w_in_use = ({1'b0, r_rd_from} < r_vc) && ({1'b0, r_rd_to} < r_vc);
        w_match  = r_rev ? (r_rd_to == r_cur_v) : (r_rd_from == r_cur_v);
        w_nb     = r_rev ? r_rd_from : r_rd_to;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_ovf    = r_ovf;
        n_vis    = r_vis;
        n_rev    = r_rev;
        n_i      = r_i;
        n_fin    = r_fin;
        n_k      = r_k;
        n_sp     = r_sp;
        n_comp   = r_comp;
        n_cur_v  = r_cur_v;
        n_cur_c  = r_cur_c;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_pend_c = r_pend_c;
        n_ov     = 1'b0;
        n_ovtx   = r_pend_v;
        n_ocomp  = r_pend_c;
        n_olast  = 1'b0;
        w_edge_we    = 1'b0;
        w_fin_we     = 1'b0;
        w_stk_we     = 1'b0;
        w_emit       = 1'b0;
        w_emit_v     = r_cur_v;
        w_emit_c     = r_comp;
        w_start_walk = 1'b0;
        w_start_v    = r_cur_v;

        case (r_state)
            scc_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_kind)
                        scc_pkg::KIND_ADD: begin
                            if (r_held < HW'(MAX_EDGES)) begin
                                w_edge_we = 1'b1;
                                n_held    = r_held + HW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        scc_pkg::KIND_CLEAR: begin
                            n_held = '0;
                            n_ovf  = 1'b0;
                        end
                        scc_pkg::KIND_RUN: begin
                            n_vis   = '0;
                            n_i     = '0;
                            n_fin   = '0;
                            n_comp  = '0;
                            n_rev   = 1'b0;
                            n_pend  = 1'b0;
                            n_state = scc_pkg::ST_P1_OUTER;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // first pass: roots in vertex order
            scc_pkg::ST_P1_OUTER: begin
                if (r_i == r_vc) begin
                    n_vis   = '0;
                    n_rev   = 1'b1;
                    n_k     = r_fin;
                    n_state = scc_pkg::ST_P2_OUTER;
                end else if (r_vis[r_i[VW-1:0]]) begin
                    n_i = r_i + NW'(1);
                end else begin
                    w_start_walk = 1'b1;
                    w_start_v    = XW'(r_i);
                end
            end
            // second pass: roots in reverse finish order
            scc_pkg::ST_P2_OUTER: begin
                if (r_k == '0) begin
                    n_state = scc_pkg::ST_FINISH;
                end else begin
                    n_state = scc_pkg::ST_P2_CHECK;
                end
            end
            scc_pkg::ST_P2_CHECK: begin
                n_k = w_k_m1;
                if (({1'b0, r_rd_fin} < r_vc) && !r_vis[r_rd_fin[VW-1:0]]) begin
                    n_comp       = r_comp + NW'(1);
                    w_start_walk = 1'b1;
                    w_start_v    = r_rd_fin;
                    w_emit_c     = r_comp + NW'(1);
                end else begin
                    n_state = scc_pkg::ST_P2_OUTER;
                end
            end
            // fetch next edge or pop the frame
            scc_pkg::ST_SCAN: begin
                if (r_cur_c < r_held) begin
                    n_state = scc_pkg::ST_CHECK;
                end else begin
                    if (!r_rev) begin
                        w_fin_we = 1'b1;
                        n_fin    = r_fin + CW'(1);
                    end
                    if (r_sp == '0) begin
                        n_state = r_rev ? scc_pkg::ST_P2_OUTER : scc_pkg::ST_P1_OUTER;
                    end else begin
                        n_state = scc_pkg::ST_POP_LOAD;
                    end
                end
            end
            scc_pkg::ST_CHECK: begin
                if (w_in_use && w_match && !r_vis[w_nb[VW-1:0]]) begin
                    w_stk_we             = 1'b1;
                    n_sp                 = r_sp + CW'(1);
                    n_vis[w_nb[VW-1:0]]  = 1'b1;
                    n_cur_v              = w_nb;
                    n_cur_c              = '0;
                    w_emit               = r_rev;
                    w_emit_v             = w_nb;
                end else begin
                    n_cur_c = r_cur_c + HW'(1);
                end
                n_state = scc_pkg::ST_SCAN;
            end
            scc_pkg::ST_POP_LOAD: begin
                n_cur_v = r_rd_sv;
                n_cur_c = r_rd_sc;
                n_sp    = w_sp_m1;
                n_state = scc_pkg::ST_SCAN;
            end
            // flush the held result as the last one
            scc_pkg::ST_FINISH: begin
                n_ov    = r_pend;
                n_olast = 1'b1;
                n_pend  = 1'b0;
                n_state = scc_pkg::ST_IDLE;
            end
            default: begin
                n_state = scc_pkg::ST_IDLE;
            end
        endcase

        // open a new walk at a root
        if (w_start_walk) begin
            n_vis[w_start_v[VW-1:0]] = 1'b1;
            n_cur_v  = w_start_v;
            n_cur_c  = '0;
            n_sp     = '0;
            w_emit   = r_rev;
            w_emit_v = w_start_v;
            n_state  = scc_pkg::ST_SCAN;
        end

        // hold one result back so the final one can carry last
        if (w_emit) begin
            n_ov     = r_pend;
            n_pend   = 1'b1;
            n_pend_v = w_emit_v;
            n_pend_c = w_emit_c;
        end
    end

    assign o_busy          = (r_state != scc_pkg::ST_IDLE);
    assign o_cfg_ready     = (r_state == scc_pkg::ST_IDLE);
    assign o_valid         = r_ov;
    assign o_vertex        = r_ovtx;
    assign o_component     = r_ocomp;
    assign o_last          = r_olast;
    assign o_edges_dropped = r_ovf;

endmodule
`default_nettype wire
